/* rtl/core/jsg_pkg.sv */
package jsg_pkg;

    localparam int FRAC_W           = 24;
    localparam int MAX_SAMPLE_COUNT = 4096;
    localparam int CNT_W            = 13;
    localparam int SLOT_W           = 16;
    localparam int RNG_W            = 64;
    localparam int HALF_W           = RNG_W / 2;
    localparam int IDX_W            = (MAX_SAMPLE_COUNT > 1) ? $clog2(MAX_SAMPLE_COUNT) : 1;
    localparam int N_W              = IDX_W + 1;
    localparam int ROOT_W           = (IDX_W + 1) / 2;
    localparam int SQ_W             = 2 * ROOT_W;
    localparam int GRID_W           = ROOT_W + 1;
    localparam int SQ_CNT_W         = $clog2(ROOT_W + 1);
    localparam int DIV_CNT_W        = $clog2(FRAC_W + 1);
    localparam int CFG_IDX_W        = 2;
    localparam int PC_W             = 6;

    localparam logic [RNG_W-1:0]  FALLBACK_WORD = 64'h9E3779B97F4A7C15;
    localparam logic [RNG_W-1:0]  STAR_MULT     = 64'h2545F4914F6CDD1D;
    localparam logic [FRAC_W-1:0] CENTER_FRAC   = {1'b1, {(FRAC_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLER_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_SAMPLES     = 2'd2;

    typedef enum logic [1:0] {
        REQ_RESEED = 2'd0,
        REQ_ONE_D  = 2'd1,
        REQ_PIXEL  = 2'd2,
        REQ_LIGHT  = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [RNG_W-1:0]  seed;
        logic [SLOT_W-1:0] sample_slot;
    } req_t;

    typedef struct packed {
        logic [FRAC_W-1:0] coord_x;
        logic [FRAC_W-1:0] coord_y;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_RESEED,
        OP_XORSHIFT,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_MUL_SUM,
        OP_SAVE_X,
        OP_SAVE_Y,
        OP_GRID_SETUP,
        OP_SQRT_STEP,
        OP_COLS,
        OP_DIV_ROWS,
        OP_DIV_CELL,
        OP_DIV_X,
        OP_DIV_Y,
        OP_DIV_STEP,
        OP_TAKE_ROWS,
        OP_TAKE_CELL,
        OP_TAKE_X,
        OP_TAKE_Y,
        OP_CENTER,
        OP_ONE_D,
        OP_PLAIN,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_REQ,
        C_RESEED,
        C_CENTER,
        C_ONE_D,
        C_PLAIN,
        C_SQRT_MORE,
        C_DIV_MORE,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        logic req_valid;
        logic reseed;
        logic center;
        logic one_d;
        logic plain;
        logic sqrt_more;
        logic div_more;
        logic out_full;
    } status_t;

    localparam logic [PC_W-1:0] L_IDLE     = 6'd0;
    localparam logic [PC_W-1:0] L_SQRT     = 6'd16;
    localparam logic [PC_W-1:0] L_ROWS_RUN = 6'd19;
    localparam logic [PC_W-1:0] L_CELL_RUN = 6'd22;
    localparam logic [PC_W-1:0] L_X_RUN    = 6'd25;
    localparam logic [PC_W-1:0] L_Y_RUN    = 6'd28;
    localparam logic [PC_W-1:0] L_EMIT     = 6'd30;
    localparam logic [PC_W-1:0] L_RESEED   = 6'd32;
    localparam logic [PC_W-1:0] L_CENTER   = 6'd33;
    localparam logic [PC_W-1:0] L_ONE_D    = 6'd34;
    localparam logic [PC_W-1:0] L_PLAIN    = 6'd35;

    function automatic ucode_t uword(input op_t op, input cond_t cond,
                                     input logic [PC_W-1:0] target);
        ucode_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            6'd0:    w = uword(OP_ACCEPT,     C_NO_REQ,    L_IDLE);
            6'd1:    w = uword(OP_NOP,        C_RESEED,    L_RESEED);
            6'd2:    w = uword(OP_NOP,        C_CENTER,    L_CENTER);
            6'd3:    w = uword(OP_XORSHIFT,   C_NEXT,      L_IDLE);
            6'd4:    w = uword(OP_MUL_LL,     C_NEXT,      L_IDLE);
            6'd5:    w = uword(OP_MUL_LH,     C_NEXT,      L_IDLE);
            6'd6:    w = uword(OP_MUL_HL,     C_NEXT,      L_IDLE);
            6'd7:    w = uword(OP_MUL_SUM,    C_NEXT,      L_IDLE);
            6'd8:    w = uword(OP_SAVE_X,     C_ONE_D,     L_ONE_D);
            6'd9:    w = uword(OP_XORSHIFT,   C_NEXT,      L_IDLE);
            6'd10:   w = uword(OP_MUL_LL,     C_NEXT,      L_IDLE);
            6'd11:   w = uword(OP_MUL_LH,     C_NEXT,      L_IDLE);
            6'd12:   w = uword(OP_MUL_HL,     C_NEXT,      L_IDLE);
            6'd13:   w = uword(OP_MUL_SUM,    C_NEXT,      L_IDLE);
            6'd14:   w = uword(OP_SAVE_Y,     C_PLAIN,     L_PLAIN);
            6'd15:   w = uword(OP_GRID_SETUP, C_NEXT,      L_IDLE);
            6'd16:   w = uword(OP_SQRT_STEP,  C_SQRT_MORE, L_SQRT);
            6'd17:   w = uword(OP_COLS,       C_NEXT,      L_IDLE);
            6'd18:   w = uword(OP_DIV_ROWS,   C_NEXT,      L_IDLE);
            6'd19:   w = uword(OP_DIV_STEP,   C_DIV_MORE,  L_ROWS_RUN);
            6'd20:   w = uword(OP_TAKE_ROWS,  C_NEXT,      L_IDLE);
            6'd21:   w = uword(OP_DIV_CELL,   C_NEXT,      L_IDLE);
            6'd22:   w = uword(OP_DIV_STEP,   C_DIV_MORE,  L_CELL_RUN);
            6'd23:   w = uword(OP_TAKE_CELL,  C_NEXT,      L_IDLE);
            6'd24:   w = uword(OP_DIV_X,      C_NEXT,      L_IDLE);
            6'd25:   w = uword(OP_DIV_STEP,   C_DIV_MORE,  L_X_RUN);
            6'd26:   w = uword(OP_TAKE_X,     C_NEXT,      L_IDLE);
            6'd27:   w = uword(OP_DIV_Y,      C_NEXT,      L_IDLE);
            6'd28:   w = uword(OP_DIV_STEP,   C_DIV_MORE,  L_Y_RUN);
            6'd29:   w = uword(OP_TAKE_Y,     C_ALWAYS,    L_EMIT);
            6'd30:   w = uword(OP_EMIT,       C_OUT_FULL,  L_EMIT);
            6'd31:   w = uword(OP_NOP,        C_ALWAYS,    L_IDLE);
            6'd32:   w = uword(OP_RESEED,     C_ALWAYS,    L_IDLE);
            6'd33:   w = uword(OP_CENTER,     C_ALWAYS,    L_EMIT);
            6'd34:   w = uword(OP_ONE_D,      C_ALWAYS,    L_EMIT);
            6'd35:   w = uword(OP_PLAIN,      C_ALWAYS,    L_EMIT);
            default: w = uword(OP_NOP,        C_ALWAYS,    L_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [N_W-1:0] limit_count(input logic [CNT_W-1:0] count);
        logic [N_W-1:0] n;
        if (count == '0)
        begin
            n = N_W'(1);
        end
        else if (32'(count) > 32'(MAX_SAMPLE_COUNT))
        begin
            n = N_W'(MAX_SAMPLE_COUNT);
        end
        else
        begin
            n = N_W'(count);
        end
        return n;
    endfunction

endpackage

/* rtl/core/jsg_divider.sv */
module jsg_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        step,
    input  logic [jsg_pkg::GRID_W-1:0]  rem_init,
    input  logic [jsg_pkg::FRAC_W-1:0]  dividend,
    input  logic [jsg_pkg::GRID_W-1:0]  divisor,
    output logic [jsg_pkg::FRAC_W-1:0]  quotient,
    output logic [jsg_pkg::GRID_W-1:0]  remainder,
    output logic                        more
);
    import jsg_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [FRAC_W-1:0]    dq_reg;
    logic [FRAC_W-1:0]    dq_next;
    logic [GRID_W-1:0]    rem_reg;
    logic [GRID_W-1:0]    rem_next;
    logic [GRID_W-1:0]    div_reg;
    logic [GRID_W-1:0]    div_next;
    logic [GRID_W:0]      trial;
    logic [GRID_W:0]      div_ext;
    logic [GRID_W:0]      diff;
    logic                 fits;

    assign trial   = {rem_reg, dq_reg[FRAC_W-1]};
    assign div_ext = {1'b0, div_reg};
    assign fits    = (trial >= div_ext);
    assign diff    = trial - div_ext;

    always_comb
    begin
        cnt_next = cnt_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(FRAC_W);
            dq_next  = dividend;
            rem_next = rem_init;
            div_next = divisor;
        end
        else if (step)
        begin
            cnt_next = cnt_reg - 1'b1;
            dq_next  = {dq_reg[FRAC_W-2:0], fits};
            rem_next = fits ? diff[GRID_W-1:0] : trial[GRID_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg;
    assign more      = (cnt_reg > DIV_CNT_W'(1));

endmodule

/* rtl/core/jsg_sequencer.sv */
module jsg_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  jsg_pkg::status_t  status,
    output jsg_pkg::ucode_t   ctrl
);
    import jsg_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NEXT:      taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_REQ:    taken = !status.req_valid;
            C_RESEED:    taken = status.reseed;
            C_CENTER:    taken = status.center;
            C_ONE_D:     taken = status.one_d;
            C_PLAIN:     taken = status.plain;
            C_SQRT_MORE: taken = status.sqrt_more;
            C_DIV_MORE:  taken = status.div_more;
            C_OUT_FULL:  taken = status.out_full;
            default:     taken = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = taken ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= L_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/core/jittered_sample_generator_top.sv */
// Sample generator for a path tracer, built on a 64-bit xorshift64* generator.
// Request channel (req_valid, req_stall, req_data): a request is taken at a rising
// edge with req_valid high and req_stall low. Type 0 reseeds the generator and the
// pixel sample index and gives no response; type 1 gives one fraction in coord_x;
// types 2 and 3 give a pixel or light point, plain or on a stratified jitter grid.
// Response channel (rsp_valid, rsp_stall, rsp_data): one registered response per
// non-reseed request; rsp_data holds while rsp_stall is high.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; write only while no request is in flight.
// One request at a time runs through a microcoded step sequencer. A stratified point
// takes four divisions at one quotient bit per cycle on the shared divider, plus a
// six-step square root for the grid width. Each draw runs an xorshift step and three
// partial products on the single 32x32 multiplier. The next request is taken while a
// response still waits on rsp_stall; a full output register holds the sequencer.
// Reset loads the default generator word, sample index 0, independent mode and one
// sample per pixel and per light, and leaves the response channel empty.
module jittered_sample_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  jsg_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output jsg_pkg::rsp_t                 rsp_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [jsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jsg_pkg::CNT_W-1:0]     cfg_data
);
    import jsg_pkg::*;

    ucode_t  ctrl;
    status_t status;

    logic                 mode_reg;
    logic                 mode_next;
    logic [CNT_W-1:0]     spp_reg;
    logic [CNT_W-1:0]     spp_next;
    logic [CNT_W-1:0]     light_reg;
    logic [CNT_W-1:0]     light_next;

    req_t                 req_reg;
    req_t                 req_next;
    logic [RNG_W-1:0]     rng_reg;
    logic [RNG_W-1:0]     rng_next;
    logic [SLOT_W-1:0]    pix_idx_reg;
    logic [SLOT_W-1:0]    pix_idx_next;

    logic [RNG_W-1:0]     prod_reg;
    logic [RNG_W-1:0]     prod_next;
    logic [HALF_W-1:0]    top_reg;
    logic [HALF_W-1:0]    top_next;
    logic [FRAC_W-1:0]    ux_reg;
    logic [FRAC_W-1:0]    ux_next;
    logic [FRAC_W-1:0]    uy_reg;
    logic [FRAC_W-1:0]    uy_next;

    logic [IDX_W-1:0]     m_reg;
    logic [IDX_W-1:0]     m_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [ROOT_W-1:0]    root_reg;
    logic [ROOT_W-1:0]    root_next;
    logic [SQ_CNT_W-1:0]  sq_cnt_reg;
    logic [SQ_CNT_W-1:0]  sq_cnt_next;
    logic [GRID_W-1:0]    cols_reg;
    logic [GRID_W-1:0]    cols_next;
    logic [GRID_W-1:0]    rows_reg;
    logic [GRID_W-1:0]    rows_next;
    logic [GRID_W-1:0]    cx_reg;
    logic [GRID_W-1:0]    cx_next;
    logic [GRID_W-1:0]    cy_reg;
    logic [GRID_W-1:0]    cy_next;

    logic [FRAC_W-1:0]    x_reg;
    logic [FRAC_W-1:0]    x_next;
    logic [FRAC_W-1:0]    y_reg;
    logic [FRAC_W-1:0]    y_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_t                 rsp_data_reg;
    rsp_t                 rsp_data_next;

    logic                 is_pixel;
    logic                 accept;
    logic                 out_full;
    logic                 emit_fire;
    logic [RNG_W-1:0]     xs1;
    logic [RNG_W-1:0]     xs2;
    logic [RNG_W-1:0]     xs3;
    logic [HALF_W-1:0]    mul_a;
    logic [HALF_W-1:0]    mul_b;
    logic [RNG_W-1:0]     product;
    logic [CNT_W-1:0]     count_sel;
    logic [SLOT_W-1:0]    index_sel;
    logic [N_W-1:0]       n_sel;
    logic [N_W-1:0]       m_sel;
    logic [ROOT_W-1:0]    bit_mask;
    logic [ROOT_W-1:0]    root_try;
    logic [SQ_W-1:0]      root_sq;

    logic                 div_start;
    logic                 div_step;
    logic                 div_more;
    logic [GRID_W-1:0]    div_rem_init;
    logic [FRAC_W-1:0]    div_dividend;
    logic [GRID_W-1:0]    div_divisor;
    logic [FRAC_W-1:0]    div_quotient;
    logic [GRID_W-1:0]    div_remainder;

    jsg_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    jsg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .step      (div_step),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .more      (div_more)
    );

    assign req_stall = (ctrl.op != OP_ACCEPT);
    assign accept    = req_valid && (ctrl.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign out_full  = rsp_valid_reg && rsp_stall;
    assign emit_fire = (ctrl.op == OP_EMIT) && !out_full;
    assign is_pixel  = (req_reg.req_type == REQ_PIXEL);

    always_comb
    begin
        status.req_valid = req_valid;
        status.reseed    = (req_reg.req_type == REQ_RESEED);
        status.center    = is_pixel && (limit_count(spp_reg) == N_W'(1));
        status.one_d     = (req_reg.req_type == REQ_ONE_D);
        status.plain     = !mode_reg;
        status.sqrt_more = (sq_cnt_reg > SQ_CNT_W'(1));
        status.div_more  = div_more;
        status.out_full  = out_full;
    end

    assign xs1 = rng_reg ^ (rng_reg >> 12);
    assign xs2 = xs1 ^ (xs1 << 25);
    assign xs3 = xs2 ^ (xs2 >> 27);

    assign mul_a   = (ctrl.op == OP_MUL_HL) ? rng_reg[RNG_W-1:HALF_W] : rng_reg[HALF_W-1:0];
    assign mul_b   = (ctrl.op == OP_MUL_LH) ? STAR_MULT[RNG_W-1:HALF_W] : STAR_MULT[HALF_W-1:0];
    assign product = mul_a * mul_b;

    assign count_sel = is_pixel ? spp_reg : light_reg;
    assign index_sel = is_pixel ? pix_idx_reg : req_reg.sample_slot;
    assign n_sel     = limit_count(count_sel);
    assign m_sel     = n_sel - 1'b1;

    assign bit_mask = ROOT_W'(1) << (sq_cnt_reg - 1'b1);
    assign root_try = root_reg | bit_mask;
    assign root_sq  = SQ_W'(root_try) * SQ_W'(root_try);

    always_comb
    begin
        div_start    = 1'b0;
        div_rem_init = '0;
        div_dividend = FRAC_W'(idx_reg);
        div_divisor  = cols_reg;
        case (ctrl.op)
            OP_DIV_ROWS:
            begin
                div_start    = 1'b1;
                div_dividend = FRAC_W'(m_reg) + FRAC_W'(cols_reg);
            end
            OP_DIV_CELL:
            begin
                div_start    = 1'b1;
            end
            OP_DIV_X:
            begin
                div_start    = 1'b1;
                div_rem_init = cx_reg;
                div_dividend = ux_reg;
            end
            OP_DIV_Y:
            begin
                div_start    = 1'b1;
                div_rem_init = cy_reg;
                div_dividend = uy_reg;
                div_divisor  = rows_reg;
            end
            default:
            begin
                div_start    = 1'b0;
            end
        endcase
    end

    assign div_step = (ctrl.op == OP_DIV_STEP);

    always_comb
    begin
        mode_next  = mode_reg;
        spp_next   = spp_reg;
        light_next = light_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SAMPLER_MODE:      mode_next  = cfg_data[0];
                CFG_SAMPLES_PER_PIXEL: spp_next   = cfg_data;
                CFG_LIGHT_SAMPLES:     light_next = cfg_data;
                default:               mode_next  = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        req_next       = accept ? req_data : req_reg;
        rng_next       = rng_reg;
        pix_idx_next   = pix_idx_reg;
        prod_next      = prod_reg;
        top_next       = top_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        m_next         = m_reg;
        idx_next       = idx_reg;
        root_next      = root_reg;
        sq_cnt_next    = sq_cnt_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (ctrl.op)
            OP_RESEED:
            begin
                rng_next     = (req_reg.seed == '0) ? FALLBACK_WORD : req_reg.seed;
                pix_idx_next = req_reg.sample_slot;
            end
            OP_XORSHIFT:
            begin
                rng_next = xs3;
            end
            OP_MUL_LL:
            begin
                prod_next = product;
            end
            OP_MUL_LH:
            begin
                top_next  = prod_reg[RNG_W-1:HALF_W];
                prod_next = product;
            end
            OP_MUL_HL:
            begin
                top_next  = top_reg + prod_reg[HALF_W-1:0];
                prod_next = product;
            end
            OP_MUL_SUM:
            begin
                top_next = top_reg + prod_reg[HALF_W-1:0];
            end
            OP_SAVE_X:
            begin
                ux_next = top_reg[HALF_W-1:HALF_W-FRAC_W];
            end
            OP_SAVE_Y:
            begin
                uy_next = top_reg[HALF_W-1:HALF_W-FRAC_W];
            end
            OP_GRID_SETUP:
            begin
                m_next      = m_sel[IDX_W-1:0];
                idx_next    = (32'(index_sel) > 32'(m_sel)) ? m_sel[IDX_W-1:0]
                                                            : index_sel[IDX_W-1:0];
                root_next   = '0;
                sq_cnt_next = SQ_CNT_W'(ROOT_W);
            end
            OP_SQRT_STEP:
            begin
                if (root_sq <= SQ_W'(m_reg))
                begin
                    root_next = root_try;
                end
                sq_cnt_next = sq_cnt_reg - 1'b1;
            end
            OP_COLS:
            begin
                cols_next = GRID_W'(root_reg) + 1'b1;
            end
            OP_TAKE_ROWS:
            begin
                rows_next = div_quotient[GRID_W-1:0];
            end
            OP_TAKE_CELL:
            begin
                cy_next = div_quotient[GRID_W-1:0];
                cx_next = div_remainder;
            end
            OP_TAKE_X:
            begin
                x_next = div_quotient;
            end
            OP_TAKE_Y:
            begin
                y_next = div_quotient;
            end
            OP_CENTER:
            begin
                x_next = CENTER_FRAC;
                y_next = CENTER_FRAC;
            end
            OP_ONE_D:
            begin
                x_next = ux_reg;
                y_next = '0;
            end
            OP_PLAIN:
            begin
                x_next = ux_reg;
                y_next = uy_reg;
            end
            OP_EMIT:
            begin
                if (emit_fire)
                begin
                    rsp_data_next.coord_x = x_reg;
                    rsp_data_next.coord_y = y_reg;
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
                rng_next = rng_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            spp_reg       <= CNT_W'(1);
            light_reg     <= CNT_W'(1);
            rng_reg       <= FALLBACK_WORD;
            pix_idx_reg   <= '0;
            sq_cnt_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            spp_reg       <= spp_next;
            light_reg     <= light_next;
            rng_reg       <= rng_next;
            pix_idx_reg   <= pix_idx_next;
            sq_cnt_reg    <= sq_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        prod_reg     <= prod_next;
        top_reg      <= top_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        m_reg        <= m_next;
        idx_reg      <= idx_next;
        root_reg     <= root_next;
        cols_reg     <= cols_next;
        rows_reg     <= rows_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

/* tb/jittered_sample_generator_top_test.sv */
module jittered_sample_generator_top_test;
    import jsg_pkg::*;

    localparam logic [63:0]          DEFAULT_WORD  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0]          XS_MULT       = 64'h2545F4914F6CDD1D;
    localparam logic [23:0]          PIXEL_CENTER  = 24'h800000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam int                   QUIET_LIMIT   = 4000;
    localparam int                   SETTLE_CYCLES = 32;
    localparam int                   SEGMENTS      = 10;
    localparam int                   SEGMENT_ITEMS = 85;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    logic [63:0] rng_state   = DEFAULT_WORD;
    logic [15:0] pixel_index = '0;
    logic        grid_mode   = 1'b0;
    logic [12:0] pixel_count = 13'd1;
    logic [12:0] light_count = 13'd1;

    req_t pending_reqs[$];
    rsp_t expected_points[$];
    rsp_t predicted;
    rsp_t want_point;
    int   send_idle    = 0;
    int   recv_idle    = 0;
    int   error_count  = 0;
    int   quiet_cycles = 0;

    jittered_sample_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [23:0] next_fraction();
        logic [63:0] w;
        logic [63:0] prod;
        w = rng_state;
        w = w ^ (w >> 12);
        w = w ^ (w << 25);
        w = w ^ (w >> 27);
        rng_state = w;
        prod = w * XS_MULT;
        return prod[63:40];
    endfunction

    function automatic int clamp_count(input logic [12:0] c);
        if (c == 13'd0)
        begin
            return 1;
        end
        if (int'(c) > MAX_SAMPLE_COUNT)
        begin
            return MAX_SAMPLE_COUNT;
        end
        return int'(c);
    endfunction

    function automatic void grid_coords(input int index, input logic [12:0] count,
                                        output logic [23:0] gx, output logic [23:0] gy);
        int          n;
        int          idx;
        int          cols;
        int          rows;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] num;
        n = clamp_count(count);
        idx = (index > n - 1) ? n - 1 : index;
        cols = 1;
        while (cols * cols < n)
        begin
            cols++;
        end
        rows = (n + cols - 1) / cols;
        ux = 64'(next_fraction());
        uy = 64'(next_fraction());
        num = (64'(idx % cols) << 24) + ux;
        gx = 24'(num / 64'(cols));
        num = (64'(idx / cols) << 24) + uy;
        gy = 24'(num / 64'(rows));
    endfunction

    function automatic bit predict_point(input req_t r, output rsp_t p);
        logic [23:0] x;
        logic [23:0] y;
        x = '0;
        y = '0;
        case (req_kind_t'(r.req_type))
            REQ_RESEED:
            begin
                rng_state = (r.seed == 64'd0) ? DEFAULT_WORD : r.seed;
                pixel_index = r.sample_slot;
                p = '0;
                return 1'b0;
            end
            REQ_ONE_D:
            begin
                x = next_fraction();
            end
            REQ_PIXEL:
            begin
                if (clamp_count(pixel_count) == 1)
                begin
                    x = PIXEL_CENTER;
                    y = PIXEL_CENTER;
                end
                else if (grid_mode)
                begin
                    grid_coords(int'(pixel_index), pixel_count, x, y);
                end
                else
                begin
                    x = next_fraction();
                    y = next_fraction();
                end
            end
            default:
            begin
                if (grid_mode)
                begin
                    grid_coords(int'(r.sample_slot), light_count, x, y);
                end
                else
                begin
                    x = next_fraction();
                    y = next_fraction();
                end
            end
        endcase
        p.coord_x = x;
        p.coord_y = y;
        return 1'b1;
    endfunction

    task automatic queue_req(input req_kind_t kind, input logic [63:0] seed,
                             input logic [15:0] slot);
        req_t r;
        r.req_type = kind;
        r.seed = seed;
        r.sample_slot = slot;
        pending_reqs.push_back(r);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLER_MODE:      grid_mode = value[0];
            CFG_SAMPLES_PER_PIXEL: pixel_count = value;
            CFG_LIGHT_SAMPLES:     light_count = value;
            default:               ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || req_valid || expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                if (predict_point(req_data, predicted))
                begin
                    expected_points.push_back(predicted);
                end
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    req_valid <= 1'b1;
                    req_data <= pending_reqs.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected response coord_x %h coord_y %h",
                       rsp_data.coord_x, rsp_data.coord_y);
                error_count++;
            end
            else
            begin
                want_point = expected_points.pop_front();
                if (rsp_data.coord_x !== want_point.coord_x)
                begin
                    $error("coord_x expected %h actual %h", want_point.coord_x, rsp_data.coord_x);
                    error_count++;
                end
                if (rsp_data.coord_y !== want_point.coord_y)
                begin
                    $error("coord_y expected %h actual %h", want_point.coord_y, rsp_data.coord_y);
                    error_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("jittered_sample_generator_top_test: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int          seg;
        int          k;
        int          pick;
        int          span;
        logic        mode_v;
        logic [12:0] spp_v;
        logic [12:0] light_v;
        req_t        r;

        send_idle = 18;
        recv_idle = 75;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: independent mode, one sample per pixel and per light
        queue_req(REQ_PIXEL, '1, '1);
        queue_req(REQ_ONE_D, '0, '0);
        queue_req(REQ_LIGHT, 64'h0123456789ABCDEF, 16'hFFFF);
        queue_req(REQ_RESEED, 64'd0, 16'd0);
        queue_req(REQ_ONE_D, '1, 16'h5A5A);
        queue_req(REQ_RESEED, '1, 16'hFFFF);
        queue_req(REQ_ONE_D, '0, '0);
        queue_req(REQ_PIXEL, '0, '0);
        queue_req(REQ_LIGHT, '0, 16'd0);
        queue_req(REQ_RESEED, 64'd1, 16'd3);
        queue_req(REQ_LIGHT, '1, 16'd1);
        settle();

        write_register(CFG_SAMPLER_MODE, 13'd1);
        write_register(CFG_SAMPLES_PER_PIXEL, 13'd9);
        write_register(CFG_LIGHT_SAMPLES, 13'd16);
        queue_req(REQ_PIXEL, '0, '0);
        queue_req(REQ_RESEED, 64'hFEDCBA9876543210, 16'd8);
        queue_req(REQ_PIXEL, '0, '0);
        queue_req(REQ_RESEED, 64'h00000000FFFFFFFF, 16'd100);
        queue_req(REQ_PIXEL, '1, '1);
        queue_req(REQ_RESEED, 64'd0, 16'd0);
        queue_req(REQ_PIXEL, '0, '0);
        queue_req(REQ_LIGHT, '0, 16'd0);
        queue_req(REQ_LIGHT, '0, 16'd15);
        queue_req(REQ_LIGHT, '0, 16'd16);
        queue_req(REQ_LIGHT, '0, 16'hFFFF);
        queue_req(REQ_ONE_D, '0, '0);
        settle();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 4)
            begin
                send_idle = 75;
                recv_idle = 18;
            end
            if (seg == 7)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (seg)
                0:
                begin
                    mode_v = 1'b1;
                    spp_v = 13'd4096;
                    light_v = 13'd4096;
                end
                1:
                begin
                    mode_v = 1'b0;
                    spp_v = 13'd0;
                    light_v = 13'd0;
                end
                2:
                begin
                    mode_v = 1'b1;
                    spp_v = 13'h1FFF;
                    light_v = 13'h1FFF;
                end
                3:
                begin
                    mode_v = 1'b1;
                    spp_v = 13'd1;
                    light_v = 13'd1;
                end
                4:
                begin
                    mode_v = 1'b1;
                    spp_v = 13'd2;
                    light_v = 13'd3;
                end
                5:
                begin
                    mode_v = 1'b0;
                    spp_v = 13'd4096;
                    light_v = 13'd1;
                end
                default:
                begin
                    mode_v = 1'($urandom_range(0, 1));
                    spp_v = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                                        : 13'($urandom_range(0, 40));
                    light_v = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                                          : 13'($urandom_range(0, 40));
                end
            endcase
            write_register(CFG_SAMPLER_MODE, {12'($urandom), mode_v});
            write_register(CFG_SAMPLES_PER_PIXEL, spp_v);
            write_register(CFG_UNUSED, 13'($urandom));
            write_register(CFG_LIGHT_SAMPLES, light_v);

            for (k = 0; k < SEGMENT_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    r.req_type = REQ_RESEED;
                    span = clamp_count(pixel_count) + 1;
                end
                else if (pick < 35)
                begin
                    r.req_type = REQ_ONE_D;
                    span = 65535;
                end
                else if (pick < 70)
                begin
                    r.req_type = REQ_PIXEL;
                    span = 65535;
                end
                else
                begin
                    r.req_type = REQ_LIGHT;
                    span = clamp_count(light_count) + 1;
                end
                r.seed = {$urandom, $urandom};
                if ($urandom_range(0, 9) == 0)
                begin
                    r.seed = '0;
                end
                r.sample_slot = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, span));
                pending_reqs.push_back(r);
            end
            settle();
        end

        if (error_count == 0)
        begin
            $display("jittered_sample_generator_top_test: clean");
        end
        else
        begin
            $display("jittered_sample_generator_top_test: errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/jsg_pkg.sv
rtl/core/jsg_divider.sv
rtl/core/jsg_sequencer.sv
rtl/core/jittered_sample_generator_top.sv
tb/jittered_sample_generator_top_test.sv
